// ----- design/matrix_multiply_engine_assert.svh -----
// Assertion macros for the matrix multiply engine
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

// same-cycle implication
`define MME_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define MME_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ----- design/mme_pkg.sv -----
// Shared types, constants and helpers for the matrix multiply engine
`default_nettype none
package mme_pkg;
   localparam int MAX_DIM     = 64;
   localparam int DIM_W       = $clog2(MAX_DIM);
   localparam int DW          = DIM_W + 1;
   localparam int SIZE_W      = 7;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int KN_W        = $clog2(STORE_DEPTH + 1);
   localparam int VAL_W       = 16;
   localparam int PROD_W      = 32;
   localparam int ACC_W       = 40;
   localparam int IDX_W       = 6;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic CSR_INNER_SIZE  = 1'b0;
   localparam logic CSR_OUT_COLUMNS = 1'b1;

   localparam logic REQ_RIGHT = 1'b0;
   localparam logic REQ_LEFT  = 1'b1;

   typedef struct packed {
      logic                    req_type;
      logic signed [VAL_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] dot_value;
      logic [IDX_W-1:0]        row_index;
      logic [IDX_W-1:0]        column_index;
      logic                    last;
   } rsp_item_type;

   function automatic logic [DW-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
      int vi;
      vi = int'(v);
      if (vi == 0) vi = 1;
      if (vi > MAX_DIM) vi = MAX_DIM;
      return DW'(vi);
   endfunction
endpackage
`default_nettype wire

// ----- design/matrix_multiply_engine.sv -----
// Timing: a right element or a left element that does not end a row is taken without going busy.
// A left element that ends a row holds busy through multiply-accumulate
// (one right-store read per cycle feeds the cell ring), a pipeline drain, then one result per column.
// Throughput: one item per cycle while idle; after a row end, busy holds until its last result.
// Reset: synchronous; clears positions, counters and sizes (both sizes to 1); stores undefined.
`default_nettype none
module matrix_multiply_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire mme_pkg::req_item_type         req_item,
   output logic                               rsp_valid,
   output mme_pkg::rsp_item_type              rsp_item,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [mme_pkg::CSR_AW-1:0]    paddr,
   input  wire logic [mme_pkg::CSR_DW-1:0]    pwdata,
   output logic      [mme_pkg::CSR_DW-1:0]    prdata,
   output logic                               pready
);
   import mme_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CALC  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0]   inner_size_ff, inner_size_in;
   logic [SIZE_W-1:0]   out_columns_ff, out_columns_in;
   logic [STORE_AW-1:0] wr_pos_ff, wr_pos_in;
   logic [DW-1:0]       lcol_ff, lcol_in;
   logic [IDX_W-1:0]    row_ff, row_in;
   logic                last_left_ff, last_left_in;
   logic [DW-1:0]       c_col_ff, c_col_in;
   logic [DW-1:0]       c_j_ff, c_j_in;
   logic [STORE_AW-1:0] c_addr_ff, c_addr_in;
   logic [DW-1:0]       e_col_ff, e_col_in;
   logic                p1_ff, p2_ff, f1_ff, f2_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic [DW-1:0]       k_dim, n_dim;
   logic [KN_W-1:0]     kn;
   logic                accept, cfg_wr, row_done, last_issue, issue, emit;
   logic [STORE_AW-1:0] wp;
   logic [KN_W-1:0]     wp_next;
   logic [DW-1:0]       lp, lp1;
   logic                right_we, left_we;
   logic [VAL_W-1:0]    right_rd, left_rd;
   logic signed [ACC_W-1:0] tap;

   assign k_dim  = clamp_dim(inner_size_ff);
   assign n_dim  = clamp_dim(out_columns_ff);
   assign kn     = KN_W'(k_dim) * KN_W'(n_dim);
   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = paddr[2] ? CSR_DW'(out_columns_ff) : CSR_DW'(inner_size_ff);
   assign issue  = (state_ff == ST_CALC);
   assign emit   = (state_ff == ST_EMIT);

   always_comb begin
      wp = last_left_ff ? '0 : wr_pos_ff;
      if (KN_W'(wp) >= kn) wp = '0;
      wp_next = KN_W'(wp) + KN_W'(1);
      if (wp_next >= kn) wp_next = '0;
      lp = (lcol_ff >= k_dim) ? '0 : lcol_ff;
      lp1 = lp + DW'(1);
   end

   assign row_done   = (lp1 >= k_dim);
   assign right_we   = accept && (req_item.req_type == REQ_RIGHT);
   assign left_we    = accept && (req_item.req_type == REQ_LEFT);
   assign last_issue = (c_j_ff == k_dim - DW'(1)) && (c_col_ff == n_dim - DW'(1));

   always_comb begin
      state_in       = state_ff;
      inner_size_in  = inner_size_ff;
      out_columns_in = out_columns_ff;
      wr_pos_in      = wr_pos_ff;
      lcol_in        = lcol_ff;
      row_in         = row_ff;
      last_left_in   = last_left_ff;
      c_col_in       = c_col_ff;
      c_j_in         = c_j_ff;
      c_addr_in      = c_addr_ff;
      e_col_in       = e_col_ff;
      if (cfg_wr) begin
         if (paddr[2] == CSR_OUT_COLUMNS) begin
            out_columns_in = pwdata[SIZE_W-1:0];
         end else begin
            inner_size_in = pwdata[SIZE_W-1:0];
         end
         wr_pos_in = '0;
         lcol_in   = '0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (right_we) begin
               if (last_left_ff) begin
                  row_in = '0;
               end
               wr_pos_in    = wp_next[STORE_AW-1:0];
               lcol_in      = last_left_ff ? '0 : lcol_ff;
               last_left_in = 1'b0;
            end else if (left_we) begin
               last_left_in = 1'b1;
               lcol_in      = row_done ? '0 : lp1;
               if (row_done) begin
                  state_in  = ST_CALC;
                  c_col_in  = '0;
                  c_j_in    = '0;
                  c_addr_in = '0;
               end
            end
         end
         ST_CALC: begin
            c_addr_in = c_addr_ff + STORE_AW'(1);
            if (c_col_ff == n_dim - DW'(1)) begin
               c_col_in = '0;
               c_j_in   = c_j_ff + DW'(1);
            end else begin
               c_col_in = c_col_ff + DW'(1);
            end
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_ff && !p2_ff) begin
               state_in = ST_EMIT;
               e_col_in = '0;
            end
         end
         ST_EMIT: begin
            e_col_in = e_col_ff + DW'(1);
            if (e_col_ff == n_dim - DW'(1)) begin
               state_in = ST_IDLE;
               row_in   = row_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         inner_size_ff  <= SIZE_W'(1);
         out_columns_ff <= SIZE_W'(1);
         wr_pos_ff      <= '0;
         lcol_ff        <= '0;
         row_ff         <= '0;
         last_left_ff   <= 1'b0;
         c_col_ff       <= '0;
         c_j_ff         <= '0;
         c_addr_ff      <= '0;
         e_col_ff       <= '0;
         p1_ff          <= 1'b0;
         p2_ff          <= 1'b0;
         f1_ff          <= 1'b0;
         f2_ff          <= 1'b0;
      end else begin
         state_ff       <= state_in;
         inner_size_ff  <= inner_size_in;
         out_columns_ff <= out_columns_in;
         wr_pos_ff      <= wr_pos_in;
         lcol_ff        <= lcol_in;
         row_ff         <= row_in;
         last_left_ff   <= last_left_in;
         c_col_ff       <= c_col_in;
         c_j_ff         <= c_j_in;
         c_addr_ff      <= c_addr_in;
         e_col_ff       <= e_col_in;
         p1_ff          <= issue;
         p2_ff          <= p1_ff;
         f1_ff          <= issue && (c_j_ff == '0);
         f2_ff          <= f1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed(left_rd) * $signed(right_rd);
   end

   mme_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_right_store (
      .clock (clock),
      .we    (right_we),
      .waddr (wp),
      .wdata (req_item.value),
      .raddr (c_addr_ff),
      .rdata (right_rd)
   );

   mme_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM)) u_left_row (
      .clock (clock),
      .we    (left_we),
      .waddr (lp[DIM_W-1:0]),
      .wdata (req_item.value),
      .raddr (c_j_ff[DIM_W-1:0]),
      .rdata (left_rd)
   );

   mme_chain u_chain (
      .clock   (clock),
      .shift   (p2_ff || emit),
      .first   (p2_ff && f2_ff),
      .product (p2_ff ? prod_ff : '0),
      .tap_sel (DIM_W'(n_dim - DW'(1))),
      .tap     (tap)
   );

   assign rsp_valid             = emit;
   assign rsp_item.dot_value    = tap;
   assign rsp_item.row_index    = row_ff;
   assign rsp_item.column_index = IDX_W'(e_col_ff);
   assign rsp_item.last         = (e_col_ff == n_dim - DW'(1));
endmodule
`default_nettype wire

// ----- design/mme_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ----- design/mme_cell.sv -----
// One accumulator cell of the column chain
`default_nettype none
module mme_cell (
   input  wire logic                               clock,
   input  wire logic                               shift,
   input  wire logic signed [mme_pkg::ACC_W-1:0]   carry_in,
   input  wire logic signed [mme_pkg::PROD_W-1:0]  addend,
   output logic signed      [mme_pkg::ACC_W-1:0]   acc
);
   import mme_pkg::*;

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (shift) begin
         acc_in = carry_in + {{(ACC_W-PROD_W){addend[PROD_W-1]}}, addend};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
endmodule
`default_nettype wire

// ----- design/mme_chain.sv -----
// Ring of column accumulator cells with a selectable tail tap
`default_nettype none
module mme_chain (
   input  wire logic                               clock,
   input  wire logic                               shift,
   input  wire logic                               first,
   input  wire logic signed [mme_pkg::PROD_W-1:0]  product,
   input  wire logic        [mme_pkg::DIM_W-1:0]   tap_sel,
   output logic signed      [mme_pkg::ACC_W-1:0]   tap
);
   import mme_pkg::*;

   logic signed [ACC_W-1:0] acc [MAX_DIM];
   logic signed [ACC_W-1:0] head_in;

   assign tap     = acc[tap_sel];
   assign head_in = first ? '0 : tap;

   for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
      if (i == 0) begin : g_head
         mme_cell u_cell (
            .clock    (clock),
            .shift    (shift),
            .carry_in (head_in),
            .addend   (product),
            .acc      (acc[i])
         );
      end else begin : g_body
         mme_cell u_cell (
            .clock    (clock),
            .shift    (shift),
            .carry_in (acc[i-1]),
            .addend   ('0),
            .acc      (acc[i])
         );
      end
   end
endmodule
`default_nettype wire

// ----- design/mme_checker.sv -----
// Port-level checks for the matrix multiply engine and their binding
`default_nettype none
`include "matrix_multiply_engine_assert.svh"
module mme_port_checks (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  rsp_valid,
   input wire mme_pkg::rsp_item_type rsp_item
);
   import mme_pkg::*;

   `MME_ASSERT_NOW(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   `MME_ASSERT_NEXT(a_right_no_rsp, clock, reset, start && !busy && !rsp_valid, !rsp_valid)
   `MME_ASSERT_NEXT(a_run_contig, clock, reset, rsp_valid && !rsp_item.last, rsp_valid)
   `MME_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_item.last, !rsp_valid && !busy)
endmodule

bind matrix_multiply_engine mme_port_checks u_mme_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire
